/* design/mspl_pkg.sv */
// Package for the motor speed PID loop: widths, constants, codes, FSM state
// and request structs for the shared serial multiplier and divider.
// No dependencies.
package mspl_pkg;

  localparam int unsigned SenseBits     = 12;
  localparam int unsigned SpeedFracBits = 4;
  localparam int unsigned SpeedW        = 18;
  localparam int unsigned ErrW          = 19;
  localparam int unsigned CfgW          = 16;
  localparam int unsigned MulW          = 66;   // product accumulator
  localparam int unsigned MplW          = 23;   // unsigned multiplier operand
  localparam int unsigned DivW          = 42;   // dividend / quotient
  localparam int unsigned DvsW          = 16;   // divisor

  // Fixed integral clamp for a tiny integral gain: 1e9 in Q32.16
  localparam logic [45:0] BigClamp = 46'd65536000000000;

  typedef enum logic [2:0] {
    CFG_GAIN_P  = 3'd0,
    CFG_GAIN_I  = 3'd1,
    CFG_GAIN_D  = 3'd2,
    CFG_WEIGHT  = 3'd3,
    CFG_SLOPE   = 3'd4,
    CFG_OFFSET  = 3'd5,
    CFG_SLIMIT  = 3'd6,
    CFG_CEILING = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMA_GO,
    S_EMA_W,
    S_ERR,
    S_LIM_W,
    S_STEP_W,
    S_ISUM,
    S_MI_GO,
    S_MI_W,
    S_MP_W,
    S_MD_W,
    S_MS_GO,
    S_MS_W,
    S_DUTY,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic                   start;
    logic [4:0]             nbits;
    logic [MplW-1:0]        mplier;
    logic signed [MulW-1:0] mcand;
  } mul_req_t;

  typedef struct packed {
    logic            start;
    logic [5:0]      nbits;
    logic [DivW-1:0] dividend;  // MSB aligned, top nbits are used
    logic [DvsW-1:0] divisor;
  } div_req_t;

endpackage

/* design/motor_speed_pid_loop.sv */
// Top level of the motor speed PID loop: sequencer, state and datapath
// around one serial multiplier and one serial divider.
// Depends on mspl_pkg, mspl_mul, mspl_div.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   in      | input     | in_valid_i/in_ready_o | raw_rpm, setpoint_rpm, sense_code, tick
//   out     | output    | out_valid_o/out_ready_i | filtered_rpm, duty, motor_on, over_current
//   cfg     | input     | cfg_we_i (no wait)   | cfg_idx_i, cfg_data_i
//
// One item at a time. A filter-only item runs a 13-bit serial multiply for
// the EMA once the filter is primed. A control tick adds two serial divides
// (42 and 31 bits) and four serial multiplies (16, 16, 23, 16 bits).
// in_ready_o is high in idle even while a result waits; the sequencer then
// holds its finished result until the output register frees. Reset restores
// the register defaults and clears all loop state.
module motor_speed_pid_loop (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [17:0] raw_rpm_i,
  input  logic signed [18:0] setpoint_rpm_i,
  input  logic [11:0] sense_code_i,
  input  logic        control_tick_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [17:0] filtered_rpm_o,
  output logic [7:0]  duty_o,
  output logic        motor_on_o,
  output logic        over_current_o
);
  import mspl_pkg::*;

  // configuration registers
  logic [15:0] gain_p_q, gain_i_q, gain_d_q, slope_q, offset_q;
  logic [12:0] weight_q, slimit_q;
  logic [13:0] ceiling_q;

  // accepted item
  logic [17:0]       raw_q;
  logic signed [18:0] sp_q;
  logic [11:0]       sense_q;
  logic              tick_q;

  // loop state
  logic [17:0]        smooth_q;
  logic               primed_q;
  logic signed [47:0] esum_q;
  logic signed [18:0] lerr_q;
  logic [7:0]         aduty_q;
  logic               den_q;
  logic               oc_q;

  // per-tick scratch
  logic signed [18:0] err_q;
  logic signed [19:0] diff_q;
  logic [45:0]        lim_q;
  logic signed [31:0] step_q;
  logic signed [55:0] eff_q;
  logic signed [65:0] val_q;

  // output register
  logic        out_valid_q;
  logic [17:0] out_rpm_q;
  logic [7:0]  out_duty_q;
  logic        out_on_q, out_oc_q;

  state_e state_q, state_d;

  mul_req_t         mul_req;
  logic             mul_done;
  logic signed [65:0] mul_prod;
  div_req_t         div_req;
  logic             div_done;
  logic [41:0]      div_quo;

  mspl_mul u_mul (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(mul_req), .done_o(mul_done), .prod_o(mul_prod)
  );

  mspl_div u_div (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(div_req), .done_o(div_done), .quo_o(div_quo)
  );

  // ---------------- datapath helpers ----------------
  logic [12:0]        w_eff;
  logic signed [18:0] ema_diff;
  logic [31:0]        ema_sum;
  logic signed [19:0] err_full;
  logic signed [18:0] err_sat;
  logic [18:0]        err_mag;
  logic [30:0]        step_num;
  logic signed [31:0] step_val;
  logic signed [48:0] isum, lim_s;
  logic signed [47:0] isum_c;
  logic [65:0]        pmag, pmag_r;
  logic signed [55:0] term_i;
  logic signed [47:0] eff_c;
  logic [22:0]        gd100;
  logic signed [65:0] val_sum, val_r;
  logic [7:0]         duty_c;
  logic               near_zero, trip;

  assign w_eff    = (weight_q > 13'd4096) ? 13'd4096 : weight_q;
  assign ema_diff = $signed({1'b0, raw_q}) - $signed({1'b0, smooth_q});
  // prev*4096 + w*(raw-prev) + half; true value stays below 2^31
  assign ema_sum  = {2'b0, smooth_q, 12'b0} + 32'(mul_prod) + 32'd2048;

  assign err_full = $signed({sp_q[18], sp_q}) - $signed({2'b0, smooth_q});
  always_comb begin
    if (err_full[19] != err_full[18]) begin
      err_sat = err_full[19] ? 19'sh40000 : 19'sh3FFFF;
    end else begin
      err_sat = err_full[18:0];
    end
  end

  assign err_mag  = err_q[18] ? 19'(-err_q) : 19'(err_q);
  assign step_num = {err_mag, 12'b0} + 31'd50;
  assign step_val = err_q[18] ? -$signed({1'b0, div_quo[30:0]})
                              : $signed({1'b0, div_quo[30:0]});

  assign isum  = 49'(esum_q) + 49'(step_q);
  assign lim_s = $signed({3'b0, lim_q});
  always_comb begin
    priority if (isum > lim_s) begin
      isum_c = 48'(lim_s);
    end else if (isum < -lim_s) begin
      isum_c = 48'(-lim_s);
    end else begin
      isum_c = isum[47:0];
    end
  end

  // round Ki*sum / 4096 to nearest, ties away from zero
  assign pmag   = mul_prod[65] ? 66'(-mul_prod) : 66'(mul_prod);
  assign pmag_r = (pmag + 66'd2048) >> 12;
  assign term_i = mul_prod[65] ? -$signed(pmag_r[55:0]) : $signed(pmag_r[55:0]);

  always_comb begin
    priority if (eff_q > 56'sh400000000000) begin
      eff_c = 48'sh400000000000;
    end else if (eff_q < -56'sh400000000000) begin
      eff_c = -48'sh400000000000;
    end else begin
      eff_c = eff_q[47:0];
    end
  end

  assign gd100 = {1'b0, gain_d_q, 6'b0} + {2'b0, gain_d_q, 5'b0} + {5'b0, gain_d_q, 2'b0};

  assign val_sum = mul_prod + $signed({26'b0, offset_q, 24'b0});
  assign val_r   = (val_q + 66'sh80000000) >>> 32;
  always_comb begin
    priority if (val_q <= 66'sd0) begin
      duty_c = 8'd0;
    end else if (val_r > 66'sd255) begin
      duty_c = 8'd255;
    end else begin
      duty_c = val_r[7:0];
    end
  end

  assign near_zero = (sp_q == 19'sd0) || (sp_q == 19'sd1) || (sp_q == -19'sd1);
  assign trip      = ({1'b0, sense_q} >= slimit_q);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    mul_req = '0;
    div_req = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EMA_GO;
        end
      end
      S_EMA_GO: begin
        if (primed_q) begin
          mul_req.start  = 1'b1;
          mul_req.nbits  = 5'd13;
          mul_req.mplier = 23'(w_eff);
          mul_req.mcand  = 66'(ema_diff);
          state_d = S_EMA_W;
        end else begin
          state_d = tick_q ? S_ERR : S_FINISH;
        end
      end
      S_EMA_W: begin
        if (mul_done) begin
          state_d = tick_q ? S_ERR : S_FINISH;
        end
      end
      S_ERR: begin
        div_req.start    = 1'b1;
        div_req.nbits    = 6'd42;
        div_req.dividend = {ceiling_q, 28'b0};
        div_req.divisor  = gain_i_q;
        state_d = S_LIM_W;
      end
      S_LIM_W: begin
        if (div_done) begin
          div_req.start    = 1'b1;
          div_req.nbits    = 6'd31;
          div_req.dividend = {step_num, 11'b0};
          div_req.divisor  = 16'd100;
          state_d = S_STEP_W;
        end
      end
      S_STEP_W: begin
        if (div_done) begin
          state_d = S_ISUM;
        end
      end
      S_ISUM: state_d = S_MI_GO;
      S_MI_GO: begin
        mul_req.start  = 1'b1;
        mul_req.nbits  = 5'd16;
        mul_req.mplier = 23'(gain_i_q);
        mul_req.mcand  = 66'(esum_q);
        state_d = S_MI_W;
      end
      S_MI_W: begin
        if (mul_done) begin
          mul_req.start  = 1'b1;
          mul_req.nbits  = 5'd16;
          mul_req.mplier = 23'(gain_p_q);
          mul_req.mcand  = 66'(err_q);
          state_d = S_MP_W;
        end
      end
      S_MP_W: begin
        if (mul_done) begin
          mul_req.start  = 1'b1;
          mul_req.nbits  = 5'd23;
          mul_req.mplier = gd100;
          mul_req.mcand  = 66'(diff_q);
          state_d = S_MD_W;
        end
      end
      S_MD_W: begin
        if (mul_done) begin
          state_d = S_MS_GO;
        end
      end
      S_MS_GO: begin
        mul_req.start  = 1'b1;
        mul_req.nbits  = 5'd16;
        mul_req.mplier = 23'(slope_q);
        mul_req.mcand  = 66'(eff_c);
        state_d = S_MS_W;
      end
      S_MS_W: begin
        if (mul_done) begin
          state_d = S_DUTY;
        end
      end
      S_DUTY: state_d = S_FINISH;
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q  <= 16'd4014;
      gain_i_q  <= 16'd2458;
      gain_d_q  <= 16'd205;
      weight_q  <= 13'd1638;
      slope_q   <= 16'd3277;
      offset_q  <= 16'd1178;
      slimit_q  <= 13'd4096;
      ceiling_q <= 14'd5000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_P:  gain_p_q  <= cfg_data_i;
        CFG_GAIN_I:  gain_i_q  <= cfg_data_i;
        CFG_GAIN_D:  gain_d_q  <= cfg_data_i;
        CFG_WEIGHT:  weight_q  <= cfg_data_i[12:0];
        CFG_SLOPE:   slope_q   <= cfg_data_i;
        CFG_OFFSET:  offset_q  <= cfg_data_i;
        CFG_SLIMIT:  slimit_q  <= cfg_data_i[12:0];
        CFG_CEILING: ceiling_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // ---------------- loop state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= '0;
      primed_q <= 1'b0;
      esum_q   <= '0;
      lerr_q   <= '0;
      aduty_q  <= '0;
      den_q    <= 1'b0;
      oc_q     <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) oc_q <= 1'b0;
        end
        S_EMA_GO: begin
          if (!primed_q) begin
            smooth_q <= raw_q;
            primed_q <= 1'b1;
          end
        end
        S_EMA_W: begin
          if (mul_done) smooth_q <= ema_sum[29:12];
        end
        S_ERR: begin
          // setpoint within one LSB (0.0625 RPM) of zero restarts the integrator
          if (near_zero) begin
            esum_q <= '0;
            lerr_q <= '0;
          end
        end
        S_ISUM: begin
          esum_q <= isum_c;
          lerr_q <= err_q;
        end
        S_DUTY: begin
          if (trip) begin
            oc_q    <= 1'b1;
            den_q   <= 1'b0;
            aduty_q <= 8'd0;
            esum_q  <= '0;
          end else begin
            den_q   <= 1'b1;
            aduty_q <= duty_c;
          end
        end
        default: ;
      endcase
    end
  end

  // item capture and tick scratch
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      raw_q   <= raw_rpm_i;
      sp_q    <= setpoint_rpm_i;
      sense_q <= sense_code_i;
      tick_q  <= control_tick_i;
    end
    if (state_q == S_ERR) begin
      err_q <= err_sat;
    end
    if (state_q == S_LIM_W && div_done) begin
      lim_q <= (gain_i_q >= 16'd5) ? 46'(div_quo) : BigClamp;
    end
    if (state_q == S_STEP_W && div_done) begin
      step_q <= step_val;
    end
    if (state_q == S_ISUM) begin
      diff_q <= $signed({err_q[18], err_q}) - $signed({lerr_q[18], lerr_q});
    end
    if (state_q == S_MI_W && mul_done) begin
      eff_q <= term_i;
    end
    if ((state_q == S_MP_W || state_q == S_MD_W) && mul_done) begin
      eff_q <= eff_q + 56'(mul_prod);
    end
    if (state_q == S_MS_W && mul_done) begin
      val_q <= val_sum;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_FINISH && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FINISH && (!out_valid_q || out_ready_i)) begin
      out_rpm_q  <= smooth_q;
      out_duty_q <= aduty_q;
      out_on_q   <= den_q && (aduty_q != 8'd0);
      out_oc_q   <= oc_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign filtered_rpm_o = out_rpm_q;
  assign duty_o         = out_duty_q;
  assign motor_on_o     = out_on_q;
  assign over_current_o = out_oc_q;
endmodule

/* design/mspl_mul.sv */
// Bit-serial shift-add multiplier: unsigned multiplier operand times signed
// multiplicand, one multiplier bit per cycle. Depends on mspl_pkg.
module mspl_mul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mspl_pkg::mul_req_t              req_i,
  output logic                            done_o,
  output logic signed [mspl_pkg::MulW-1:0] prod_o
);
  import mspl_pkg::*;

  logic                   busy_q, done_q;
  logic [4:0]             cnt_q;
  logic [MplW-1:0]        mp_q;
  logic signed [MulW-1:0] mc_q, acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.nbits;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      mc_q  <= req_i.mcand;
      mp_q  <= req_i.mplier;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= mc_q <<< 1;
      mp_q <= mp_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule

/* design/mspl_div.sv */
// Restoring bit-serial divider, one quotient bit per cycle over the top
// nbits of an MSB-aligned dividend. Depends on mspl_pkg.
module mspl_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mspl_pkg::div_req_t        req_i,
  output logic                      done_o,
  output logic [mspl_pkg::DivW-1:0] quo_o
);
  import mspl_pkg::*;

  logic            busy_q, done_q;
  logic [5:0]      cnt_q;
  logic [DivW-1:0] dd_q, quo_q;
  logic [DvsW-1:0] dvs_q, rem_q;
  logic [DvsW:0]   trial;
  logic            fits;

  assign trial = {rem_q, dd_q[DivW-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.nbits;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dd_q  <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dd_q  <= dd_q << 1;
      quo_q <= {quo_q[DivW-2:0], fits};
      if (fits) begin
        rem_q <= DvsW'(trial - {1'b0, dvs_q});
      end else begin
        rem_q <= trial[DvsW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

/* design/mspl_checker.sv */
// Port-level checker for the motor speed PID loop, bound to the top level.
// Depends on motor_speed_pid_loop.
module mspl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] duty_o,
  input logic       motor_on_o,
  input logic       over_current_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(duty_o))
    else $error("result dropped or changed while stalled");

  a_trip_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && over_current_o |-> duty_o == 8'd0 && !motor_on_o)
    else $error("over-current result with drive on");

  a_on_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motor_on_o |-> duty_o != 8'd0)
    else $error("motor on with zero duty");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in work");

endmodule

bind motor_speed_pid_loop mspl_checker u_mspl_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .duty_o(duty_o),
  .motor_on_o(motor_on_o), .over_current_o(over_current_o)
);
